// ===== hdl/joint_dmp_step_assert.svh =====
// assertion macros shared by the joint_dmp_step checker
// depends on: a clk and a rst signal in the scope of each use
`ifndef JOINT_DMP_STEP_ASSERT_SVH
`define JOINT_DMP_STEP_ASSERT_SVH

// same-cycle implication, off while in reset
`define JDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("joint_dmp_step check failed");

// next-cycle implication, off while in reset
`define JDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("joint_dmp_step check failed");

`endif

// ===== hdl/jds_pkg.sv =====
// types, constants and fixed-point helpers for joint_dmp_step
// no dependencies; imported by the top level, the checkers and the testbench
`timescale 1ns / 1ps

package jds_pkg;

  localparam int DW          = 32;
  localparam int FRAC        = 24;
  localparam int WIDE        = 40;
  localparam int JOINTS      = 7;
  localparam int MAX_BASIS   = 8;
  localparam int MAX_SENSORS = 2;
  localparam int WT_DEPTH    = JOINTS * MAX_SENSORS * MAX_BASIS;
  localparam int WT_AW       = 7;
  localparam int DIV_STEPS   = DW + FRAC;

  typedef logic signed [DW-1:0] q_t;

  localparam q_t ONE_Q = 32'sd16777216;
  localparam q_t LN2_Q = 32'sd11629080;
  localparam q_t MAXV  = 32'sh7fffffff;
  localparam q_t MINV  = 32'sh80000000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_TABLE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    SEL_WEIGHT = 2'd0,
    SEL_CENTER = 2'd1,
    SEL_WIDTH  = 2'd2
  } table_sel_t;

  typedef enum logic [2:0] {
    CFG_TIME_SCALE   = 3'd0,
    CFG_OUTER_GAIN   = 3'd1,
    CFG_POS_RATIO    = 3'd2,
    CFG_STEP_TIME    = 3'd3,
    CFG_BASIS_COUNT  = 3'd4,
    CFG_SENSOR_COUNT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        joint_index;
    logic              sensor_index;
    logic [2:0]        basis_index;
    logic [1:0]        table_select;
    logic signed [31:0] table_value;
    logic signed [31:0] start_position;
    logic signed [31:0] start_velocity;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         out_joint;
    logic signed [31:0] joint_target;
    logic signed [31:0] joint_rate;
    logic               last_joint;
  } result_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_B_DIFF, ST_B_SQ, ST_B_WID, ST_B_RANGE, ST_B_RED,
    ST_B_TM, ST_B_TD, ST_B_TA, ST_B_SCALE, ST_B_STORE,
    ST_N_MUL, ST_N_DIV, ST_N_STORE,
    ST_L_START, ST_L_NORM, ST_L_ZSQ, ST_L_Z2, ST_L_TD, ST_L_TA, ST_L_PW,
    ST_L_M, ST_L_DIV, ST_L_T,
    ST_T_SQ, ST_T_CUBE, ST_T_POLY, ST_T_ACT, ST_T_STORE,
    ST_J_DIFF, ST_J_BD, ST_J_SUB, ST_J_ALPHA, ST_J_SPR, ST_J_RD, ST_J_WMUL,
    ST_J_ACC, ST_J_AB, ST_J_ABN, ST_J_FRC, ST_J_DIV, ST_J_VEL, ST_J_VUPD,
    ST_J_PMUL, ST_J_PUPD,
    ST_P_TAU, ST_P_DT, ST_P_UPD,
    ST_DIV
  } state_t;

  // sign-extend a value to the wide working width
  function automatic logic signed [WIDE-1:0] wx(input q_t v);
    return WIDE'(v);
  endfunction

  // clamp a wide value to the data range
  function automatic q_t sat_wide(input logic signed [WIDE-1:0] v);
    q_t r;
    if (v > wx(MAXV)) r = MAXV;
    else if (v < wx(MINV)) r = MINV;
    else r = v[DW-1:0];
    return r;
  endfunction

  // magnitude of a signed value
  function automatic logic [DW-1:0] mag(input q_t v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // signed value from sign and magnitude, clamped
  function automatic q_t from_mag(input logic neg, input logic [63:0] m);
    q_t r;
    if (!neg) r = (m > 64'(MAXV)) ? MAXV : q_t'(m[DW-1:0]);
    else if (m > 64'(MAXV) + 64'd1) r = MINV;
    else r = q_t'(-m[DW-1:0]);
    return r;
  endfunction

  // floor(2^31 / i) + 1, exact quotient for dividends below 2^26
  function automatic logic [DW-1:0] recip(input logic [3:0] i);
    logic [DW-1:0] r;
    case (i)
      4'd1:    r = 32'd2147483649;
      4'd2:    r = 32'd1073741825;
      4'd3:    r = 32'd715827883;
      4'd4:    r = 32'd536870913;
      4'd5:    r = 32'd429496730;
      4'd6:    r = 32'd357913942;
      4'd7:    r = 32'd306783379;
      4'd8:    r = 32'd268435457;
      4'd9:    r = 32'd238609295;
      4'd10:   r = 32'd214748365;
      4'd11:   r = 32'd195225787;
      4'd12:   r = 32'd178956971;
      4'd13:   r = 32'd165191050;
      4'd14:   r = 32'd153391690;
      4'd15:   r = 32'd143165577;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/joint_dmp_step.sv =====
// joint_dmp_step: joint-space movement primitive, one tick per command
// depends on jds_pkg (types, constants, fixed-point helpers)
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------
//  command  | start, busy             | cmd (cmd_t)
//  config   | cfg_write               | cfg_index, cfg_data
//  result   | result_valid (strobe)   | result (result_t)
//
// a load command is taken while idle and busy stays low
// a tick runs on one shared 32x32 multiplier and one radix-2 divider
// (56 quotient bits); the divider and the exp range reduction take
// most of its time
// seven results come, one per joint; no stall
// reset restores config registers, start state and phase; tables stay unwritten
`timescale 1ns / 1ps

module joint_dmp_step
  import jds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output result_t     result,
  output logic        result_valid
);

  // configuration
  logic [30:0] tau, alpha, beta;
  logic [24:0] dt;
  logic [3:0]  bcount;
  logic [1:0]  scount;
  logic [3:0]  nb;
  logic [1:0]  ns;
  q_t          tau_q, alpha_q, beta_q, dt_q;

  // movement state and tables
  q_t phase;
  q_t goal [JOINTS];
  q_t pos  [JOINTS];
  q_t vel  [JOINTS];
  q_t ctr  [MAX_BASIS];
  q_t wid  [MAX_BASIS];
  q_t act  [MAX_BASIS];
  q_t wmem [WT_DEPTH];
  q_t wrd;

  // sequencer
  state_t state, state_next, div_ret, div_ret_next;
  logic [3:0] k;
  logic [2:0] jj;
  logic [1:0] ss;
  logic [3:0] ti;

  // working registers
  q_t wa, wb, ev, den, ddy, feat, fsum, tt, t2, t3, poly;
  logic signed [5:0] en, lm;
  logic [29:0] rr;
  logic [24:0] term, pw, z2;
  logic [26:0] esum, lsum;
  logic [31:0] y;

  // shared multiplier
  q_t ma_s, mb_s;
  logic mraw;
  logic [DW-1:0] mx, my;
  logic mn, mneg;
  logic [63:0] mp;
  q_t mulq_res;

  // shared divider
  logic div_load;
  q_t div_a, div_b;
  logic [55:0] dq;
  logic [32:0] drem, dtrial;
  logic [31:0] dv;
  logic [5:0]  dcnt;
  logic dneg, da_neg, da_zero;
  q_t div_res;

  // misc combinational terms
  logic accept;
  logic [WT_AW-1:0] wr_addr, rd_addr;
  logic signed [WIDE-1:0] exp_arg, lnv, mln;
  q_t feat_sum, poly_p1;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign tau_q   = q_t'({1'b0, tau});
  assign alpha_q = q_t'({1'b0, alpha});
  assign beta_q  = q_t'({1'b0, beta});
  assign dt_q    = q_t'({7'b0, dt});
  assign nb      = (bcount > 4'(MAX_BASIS)) ? 4'(MAX_BASIS) : bcount;
  assign ns      = (scount > 2'(MAX_SENSORS)) ? 2'(MAX_SENSORS) : scount;
  assign wr_addr = {cmd.joint_index, cmd.sensor_index, cmd.basis_index};
  assign rd_addr = {jj, ss[0], k[2:0]};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tau    <= 31'd16777216;
      alpha  <= 31'd419430400;
      beta   <= 31'd104857600;
      dt     <= 25'd16777;
      bcount <= 4'd6;
      scount <= 2'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIME_SCALE:   tau    <= cfg_data;
        CFG_OUTER_GAIN:   alpha  <= cfg_data;
        CFG_POS_RATIO:    beta   <= cfg_data;
        CFG_STEP_TIME:    dt     <= cfg_data[24:0];
        CFG_BASIS_COUNT:  bcount <= cfg_data[3:0];
        CFG_SENSOR_COUNT: scount <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // exponent argument and log result for the range and divide steps
  assign exp_arg  = -wx(mulq_res);
  assign mln      = mneg ? -$signed(mp[WIDE-1:0]) : $signed(mp[WIDE-1:0]);
  assign lnv      = $signed({12'b0, lsum, 1'b0}) + mln;
  assign feat_sum = sat_wide(wx(feat) + wx(mulq_res));
  assign poly_p1  = sat_wide(wx(t2) * 40'sd6 - wx(tt) * 40'sd15);

  // next state, multiplier operands, divider launch
  always_comb begin
    state_next   = state;
    div_ret_next = div_ret;
    div_load     = 1'b0;
    div_a        = '0;
    div_b        = '0;
    ma_s         = '0;
    mb_s         = '0;
    mraw         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.action == ACT_TICK) state_next = ST_B_DIFF;
      end
      // gaussian activations
      ST_B_DIFF: state_next = (k == nb) ? ST_N_MUL : ST_B_SQ;
      ST_B_SQ: begin
        ma_s = wa; mb_s = wa;
        state_next = ST_B_WID;
      end
      ST_B_WID: begin
        ma_s = wid[k[2:0]]; mb_s = mulq_res;
        state_next = ST_B_RANGE;
      end
      ST_B_RANGE: begin
        if (exp_arg >= 40'sd93032640 || exp_arg < -40'sd348872400)
          state_next = ST_B_STORE;
        else state_next = ST_B_RED;
      end
      ST_B_RED: if (rr < 30'(LN2_Q)) state_next = ST_B_TM;
      ST_B_TM: begin
        mraw = 1'b1; ma_s = q_t'({7'b0, term}); mb_s = q_t'({2'b0, rr});
        state_next = ST_B_TD;
      end
      ST_B_TD: begin
        mraw = 1'b1; ma_s = q_t'(mp[55:24]); mb_s = q_t'(recip(ti));
        state_next = ST_B_TA;
      end
      ST_B_TA:    state_next = (ti == 4'd12) ? ST_B_SCALE : ST_B_TM;
      ST_B_SCALE: state_next = ST_B_STORE;
      ST_B_STORE: state_next = ST_B_DIFF;
      // normalization of bases above zero
      ST_N_MUL: begin
        ma_s = act[k[2:0]]; mb_s = phase;
        state_next = (k >= nb) ? ST_L_START : ST_N_DIV;
      end
      ST_N_DIV: begin
        div_load = 1'b1; div_a = mulq_res; div_b = sat_wide(wx(den) + 40'sd1);
        div_ret_next = ST_N_STORE;
        state_next = ST_DIV;
      end
      ST_N_STORE: state_next = ST_N_MUL;
      // natural log of the phase
      ST_L_START: state_next = (phase <= 0) ? ST_T_SQ : ST_L_NORM;
      ST_L_NORM: begin
        if (y[31:25] == '0 && y[24]) begin
          div_load = 1'b1; div_a = q_t'(y) - ONE_Q; div_b = q_t'(y) + ONE_Q;
          div_ret_next = ST_L_ZSQ;
          state_next = ST_DIV;
        end
      end
      ST_L_ZSQ: begin
        ma_s = div_res; mb_s = div_res;
        state_next = ST_L_Z2;
      end
      ST_L_Z2: state_next = ST_L_TD;
      ST_L_TD: begin
        mraw = 1'b1; ma_s = q_t'({7'b0, pw}); mb_s = q_t'(recip(ti));
        state_next = ST_L_TA;
      end
      ST_L_TA: begin
        mraw = 1'b1; ma_s = q_t'({7'b0, pw}); mb_s = q_t'({7'b0, z2});
        state_next = (ti == 4'd15) ? ST_L_M : ST_L_PW;
      end
      ST_L_PW: state_next = ST_L_TD;
      ST_L_M: begin
        ma_s = q_t'(lm); mb_s = LN2_Q;
        state_next = ST_L_DIV;
      end
      ST_L_DIV: begin
        div_load = 1'b1; div_a = -lnv[DW-1:0]; div_b = tau_q;
        div_ret_next = ST_L_T;
        state_next = ST_DIV;
      end
      ST_L_T: state_next = ST_T_SQ;
      // minimum-jerk basis
      ST_T_SQ: begin
        ma_s = tt; mb_s = tt;
        state_next = ST_T_CUBE;
      end
      ST_T_CUBE: begin
        ma_s = mulq_res; mb_s = tt;
        state_next = ST_T_POLY;
      end
      ST_T_POLY: state_next = ST_T_ACT;
      ST_T_ACT: begin
        ma_s = t3; mb_s = poly;
        state_next = ST_T_STORE;
      end
      ST_T_STORE: state_next = ST_J_DIFF;
      // per-joint integration
      ST_J_DIFF: begin
        ma_s = tau_q; mb_s = vel[jj];
        state_next = ST_J_BD;
      end
      ST_J_BD: begin
        ma_s = beta_q; mb_s = wa;
        state_next = ST_J_SUB;
      end
      ST_J_SUB: state_next = ST_J_ALPHA;
      ST_J_ALPHA: begin
        ma_s = alpha_q; mb_s = wa;
        state_next = ST_J_SPR;
      end
      ST_J_SPR: state_next = (nb == '0 || ns == '0) ? ST_J_AB : ST_J_RD;
      ST_J_RD:  state_next = ST_J_WMUL;
      ST_J_WMUL: begin
        ma_s = act[k[2:0]]; mb_s = wrd;
        state_next = ST_J_ACC;
      end
      ST_J_ACC: begin
        if (4'(k + 4'd1) == nb && 2'(ss + 2'd1) == ns) state_next = ST_J_AB;
        else state_next = ST_J_RD;
      end
      ST_J_AB: begin
        ma_s = alpha_q; mb_s = beta_q;
        state_next = ST_J_ABN;
      end
      ST_J_ABN: begin
        ma_s = mulq_res; mb_s = fsum;
        state_next = ST_J_FRC;
      end
      ST_J_FRC: begin
        ma_s = tau_q; mb_s = tau_q;
        state_next = ST_J_DIV;
      end
      ST_J_DIV: begin
        div_load = 1'b1; div_a = ddy; div_b = mulq_res;
        div_ret_next = ST_J_VEL;
        state_next = ST_DIV;
      end
      ST_J_VEL: begin
        ma_s = div_res; mb_s = dt_q;
        state_next = ST_J_VUPD;
      end
      ST_J_VUPD: state_next = ST_J_PMUL;
      ST_J_PMUL: begin
        ma_s = vel[jj]; mb_s = dt_q;
        state_next = ST_J_PUPD;
      end
      ST_J_PUPD: state_next = (jj == 3'(JOINTS - 1)) ? ST_P_TAU : ST_J_DIFF;
      // phase decay
      ST_P_TAU: begin
        ma_s = phase; mb_s = tau_q;
        state_next = ST_P_DT;
      end
      ST_P_DT: begin
        ma_s = mulq_res; mb_s = dt_q;
        state_next = ST_P_UPD;
      end
      ST_P_UPD: state_next = ST_IDLE;
      ST_DIV:   if (dcnt == 6'(DIV_STEPS - 1)) state_next = div_ret;
      default:  state_next = ST_IDLE;
    endcase
  end

  // multiplier operands: sign and magnitude, or raw unsigned
  always_comb begin
    if (mraw) begin
      mx = ma_s; my = mb_s; mn = 1'b0;
    end else begin
      mx = mag(ma_s); my = mag(mb_s); mn = ma_s[DW-1] ^ mb_s[DW-1];
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    mp   <= 64'(mx) * 64'(my);
    mneg <= mn;
  end

  assign mulq_res = from_mag(mneg, mp >> FRAC);

  // shared restoring divider, one quotient bit a cycle
  assign dtrial = {drem[31:0], dq[55]};

  always_ff @(posedge clk) begin
    if (div_load) begin
      dq      <= {mag(div_a), 24'b0};
      drem    <= '0;
      dv      <= mag(div_b);
      dcnt    <= '0;
      dneg    <= div_a[DW-1] ^ div_b[DW-1];
      da_neg  <= div_a[DW-1];
      da_zero <= (div_a == '0);
      div_ret <= div_ret_next;
    end else if (state == ST_DIV) begin
      dcnt <= dcnt + 6'd1;
      if (dtrial >= {1'b0, dv}) begin
        drem <= dtrial - {1'b0, dv};
        dq   <= {dq[54:0], 1'b1};
      end else begin
        drem <= dtrial;
        dq   <= {dq[54:0], 1'b0};
      end
    end
  end

  assign div_res = (dv == '0) ? (da_zero ? q_t'(0) : (da_neg ? MINV : MAXV))
                              : from_mag(dneg, 64'(dq));

  // weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && cmd.action == ACT_TABLE && cmd.table_select == SEL_WEIGHT &&
        cmd.joint_index < 3'(JOINTS))
      wmem[wr_addr] <= cmd.table_value;
    wrd <= wmem[rd_addr];
  end

  // joint start state and phase, reset to zero and one
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ONE_Q;
      for (int i = 0; i < JOINTS; i++) begin
        goal[i] <= '0;
        pos[i]  <= '0;
        vel[i]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && cmd.action == ACT_START && cmd.joint_index < 3'(JOINTS)) begin
            goal[cmd.joint_index] <= cmd.start_position;
            pos[cmd.joint_index]  <= cmd.start_position;
            vel[cmd.joint_index]  <= cmd.start_velocity;
            phase                 <= ONE_Q;
          end
        end
        ST_J_VUPD: vel[jj] <= sat_wide(wx(vel[jj]) + wx(mulq_res));
        ST_J_PUPD: pos[jj] <= sat_wide(wx(pos[jj]) + wx(mulq_res));
        ST_P_UPD:  phase   <= sat_wide(wx(phase) - wx(mulq_res));
        default: ;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= (state == ST_J_PUPD);
  end

  // sequencer working registers and small tables
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        k   <= '0;
        den <= '0;
        if (accept && cmd.action == ACT_TABLE) begin
          if (cmd.table_select == SEL_CENTER) ctr[cmd.basis_index] <= cmd.table_value;
          if (cmd.table_select == SEL_WIDTH)  wid[cmd.basis_index] <= cmd.table_value;
        end
      end
      ST_B_DIFF: begin
        if (k == nb) k <= 4'd1;
        else wa <= sat_wide(wx(phase) - wx(ctr[k[2:0]]));
      end
      ST_B_RANGE: begin
        rr <= 30'(exp_arg + 40'sd348872400);
        en <= -6'sd30;
        if (exp_arg >= 40'sd93032640) ev <= MAXV;
        else ev <= '0;
      end
      ST_B_RED: begin
        if (rr >= 30'(LN2_Q)) begin
          rr <= rr - 30'(LN2_Q);
          en <= en + 6'sd1;
        end else begin
          term <= 25'(ONE_Q);
          esum <= 27'(ONE_Q);
          ti   <= 4'd1;
        end
      end
      ST_B_TA: begin
        term <= mp[55:31];
        esum <= esum + 27'(mp[55:31]);
        ti   <= ti + 4'd1;
      end
      ST_B_SCALE: begin
        if (en >= 0) ev <= sat_wide(WIDE'(esum) << en);
        else ev <= q_t'({5'b0, esum} >> 6'(-en));
      end
      ST_B_STORE: begin
        act[k[2:0]] <= ev;
        if (k != '0) den <= sat_wide(wx(den) + wx(ev));
        k <= k + 4'd1;
      end
      ST_N_STORE: begin
        act[k[2:0]] <= div_res;
        k <= k + 4'd1;
      end
      ST_L_START: begin
        tt <= ONE_Q;
        y  <= phase;
        lm <= '0;
      end
      ST_L_NORM: begin
        if (y[31:25] != '0) begin
          y  <= y >> 1;
          lm <= lm + 6'sd1;
        end else if (!y[24]) begin
          y  <= y << 1;
          lm <= lm - 6'sd1;
        end
      end
      ST_L_ZSQ: pw <= div_res[24:0];
      ST_L_Z2: begin
        z2   <= mp[48:24];
        lsum <= '0;
        ti   <= 4'd1;
      end
      ST_L_TA:  lsum <= lsum + 27'(mp[55:31]);
      ST_L_PW: begin
        pw <= mp[48:24];
        ti <= ti + 4'd2;
      end
      ST_L_T:    tt <= (div_res > ONE_Q) ? ONE_Q : div_res;
      ST_T_CUBE: t2 <= mulq_res;
      ST_T_POLY: begin
        t3   <= mulq_res;
        poly <= sat_wide(wx(poly_p1) + wx(ONE_Q) * 40'sd10);
      end
      ST_T_STORE: begin
        if (nb != '0) act[0] <= mulq_res;
        jj <= '0;
      end
      ST_J_DIFF: wa <= sat_wide(wx(goal[jj]) - wx(pos[jj]));
      ST_J_BD:   wb <= mulq_res;
      ST_J_SUB:  wa <= sat_wide(wx(mulq_res) - wx(wb));
      ST_J_SPR: begin
        ddy  <= mulq_res;
        fsum <= '0;
        feat <= '0;
        k    <= '0;
        ss   <= '0;
      end
      ST_J_ACC: begin
        if (4'(k + 4'd1) == nb) begin
          fsum <= sat_wide(wx(fsum) + wx(feat_sum));
          feat <= '0;
          k    <= '0;
          ss   <= ss + 2'd1;
        end else begin
          feat <= feat_sum;
          k    <= k + 4'd1;
        end
      end
      ST_J_FRC: ddy <= sat_wide(wx(ddy) + wx(mulq_res));
      ST_J_PUPD: begin
        result.out_joint    <= jj;
        result.joint_target <= sat_wide(wx(pos[jj]) + wx(mulq_res));
        result.joint_rate   <= vel[jj];
        result.last_joint   <= (jj == 3'(JOINTS - 1));
        jj <= jj + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/jds_checker.sv =====
// port-level checks for joint_dmp_step, bound to the top level
// depends on jds_pkg and joint_dmp_step_assert.svh
`timescale 1ns / 1ps
`include "joint_dmp_step_assert.svh"

module jds_checker
  import jds_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input result_t result,
  input logic    result_valid
);

  // results only come out during a tick
  `JDS_ASSERT_NOW(a_result_in_tick, result_valid, busy)

  // the last-joint flag marks exactly the final joint
  `JDS_ASSERT_NOW(a_last_flag, result_valid, result.last_joint == (result.out_joint == 3'd6))

  // nothing follows the final joint transfer directly
  `JDS_ASSERT_NEXT(a_last_ends, result_valid && result.last_joint, !result_valid)

  // an accepted tick makes the block busy
  `JDS_ASSERT_NEXT(a_tick_busy, start && !busy && cmd.action == ACT_TICK, busy)

  // a load never makes the block busy
  `JDS_ASSERT_NEXT(a_load_idle, start && !busy && cmd.action != ACT_TICK, !busy)

endmodule

bind joint_dmp_step jds_checker u_jds_checker (.*);

// ===== tb/dmp_tick_checker.sv =====
// checker for joint_dmp_step: mirrors the movement-primitive tick in fixed point
// depends on jds_pkg (cmd_t, result_t, action and select codes, register indexes)
`timescale 1ns / 1ps

module dmp_tick_checker
  import jds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  result_t     result,
  input  logic        result_valid,
  output int          pending,
  output int          errors
);

  localparam longint Q_ONE = 64'sd16777216;
  localparam longint Q_LN2 = 64'sd11629080;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // mirrored block state
  longint goal_q[JOINTS], pos_q[JOINTS], vel_q[JOINTS], phase_q;
  longint weight_q[WT_DEPTH], center_q[MAX_BASIS], width_q[MAX_BASIS], act_q[MAX_BASIS];
  longint tau_r, alpha_r, beta_r, dt_r, basis_r, sensor_r;
  result_t joint_results[$];

  function automatic longint clamp(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed_of(bit neg, longint unsigned m);
    if (!neg) return m > Q_MAX ? Q_MAX : longint'(m);
    if (m > 64'd2147483648) return Q_MIN;
    return -longint'(m);
  endfunction

  // truncating fixed-point product
  function automatic longint qmul(longint a, longint b);
    longint unsigned p;
    p = absval(a) * absval(b);
    return signed_of((a < 0) != (b < 0), p >> FRAC);
  endfunction

  // truncating fixed-point quotient, saturating on a zero divisor
  function automatic longint qdiv(longint a, longint b);
    longint unsigned ua, ub;
    ua = absval(a);
    ub = absval(b);
    if (ub == 0) return a == 0 ? 0 : (a > 0 ? Q_MAX : Q_MIN);
    return signed_of((a < 0) != (b < 0), (ua << FRAC) / ub);
  endfunction

  // exp by ln2 range reduction and a taylor series
  function automatic longint qexp(longint a);
    longint n, r, term, sum;
    term = Q_ONE;
    sum = Q_ONE;
    if (a >= 0) n = a / Q_LN2;
    else n = -((-a + Q_LN2 - 1) / Q_LN2);
    if (n < -30) return 0;
    if (n > DW - 1 - FRAC) return Q_MAX;
    r = a - n * Q_LN2;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * r) >>> FRAC) / i;
      sum += term;
    end
    if (n >= 0) return clamp(sum << n);
    return sum >>> (-n);
  endfunction

  // natural log of a positive value via an atanh series
  function automatic longint qln(longint x);
    int p;
    longint y, m, z, z2, pw, sum;
    p = 0;
    sum = 0;
    while (p < 62 && (x >>> (p + 1)) != 0) p++;
    m = p - FRAC;
    y = p >= FRAC ? (x >>> (p - FRAC)) : (x << (FRAC - p));
    z = qdiv(y - Q_ONE, y + Q_ONE);
    z2 = (z * z) >>> FRAC;
    pw = z;
    for (int d = 1; d <= 15; d += 2) begin
      sum += pw / d;
      pw = (pw * z2) >>> FRAC;
    end
    return 2 * sum + m * Q_LN2;
  endfunction

  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  task automatic reset_model();
    for (int i = 0; i < JOINTS; i++) begin
      goal_q[i] = 0; pos_q[i] = 0; vel_q[i] = 0;
    end
    for (int i = 0; i < WT_DEPTH; i++) weight_q[i] = 0;
    for (int k = 0; k < MAX_BASIS; k++) begin
      center_q[k] = 0; width_q[k] = 0; act_q[k] = 0;
    end
    phase_q = Q_ONE;
    tau_r = 16777216; alpha_r = 419430400; beta_r = 104857600;
    dt_r = 16777; basis_r = 6; sensor_r = 2;
    joint_results.delete();
  endtask

  // one tick: activations, normalization, min-jerk basis, per-joint integration, then phase decay
  task automatic predict_tick();
    longint den, t, t2, poly, d, e, ddy, net, feat, diff;
    int nb, ns;
    result_t r;
    den = 0;
    nb = basis_r > MAX_BASIS ? MAX_BASIS : int'(basis_r);
    ns = sensor_r > MAX_SENSORS ? MAX_SENSORS : int'(sensor_r);
    for (int k = 0; k < nb; k++) begin
      d = clamp(phase_q - center_q[k]);
      e = qmul(width_q[k], qmul(d, d));
      act_q[k] = qexp(-e);
      if (k > 0) den = clamp(den + act_q[k]);
    end
    for (int k = 1; k < nb; k++)
      act_q[k] = qdiv(qmul(act_q[k], phase_q), clamp(den + 1));
    if (phase_q <= 0) t = Q_ONE;
    else begin
      t = qdiv(-qln(phase_q), tau_r);
      if (t > Q_ONE) t = Q_ONE;
    end
    t2 = qmul(t, t);
    poly = clamp(clamp(6 * t2 - 15 * t) + 10 * Q_ONE);
    if (nb > 0) act_q[0] = qmul(qmul(t2, t), poly);
    for (int i = 0; i < JOINTS; i++) begin
      net = 0;
      diff = clamp(goal_q[i] - pos_q[i]);
      ddy = qmul(alpha_r, clamp(qmul(beta_r, diff) - qmul(tau_r, vel_q[i])));
      for (int j = 0; j < ns; j++) begin
        feat = 0;
        for (int k = 0; k < nb; k++)
          feat = clamp(feat + qmul(act_q[k], weight_q[(i * MAX_SENSORS + j) * MAX_BASIS + k]));
        net = clamp(net + feat);
      end
      ddy = clamp(ddy + qmul(qmul(alpha_r, beta_r), net));
      ddy = qdiv(ddy, qmul(tau_r, tau_r));
      vel_q[i] = clamp(vel_q[i] + qmul(ddy, dt_r));
      pos_q[i] = clamp(pos_q[i] + qmul(vel_q[i], dt_r));
      r.out_joint    = 3'(i);
      r.joint_target = 32'(pos_q[i]);
      r.joint_rate   = 32'(vel_q[i]);
      r.last_joint   = (i == JOINTS - 1);
      joint_results.push_back(r);
    end
    phase_q = clamp(phase_q - qmul(qmul(phase_q, tau_r), dt_r));
  endtask

  // command transfer updates the mirror
  task automatic apply_cmd(cmd_t c);
    int wi;
    case (c.action)
      ACT_TICK: predict_tick();
      ACT_START: begin
        if (c.joint_index < JOINTS) begin
          goal_q[c.joint_index] = sext(c.start_position);
          pos_q[c.joint_index]  = sext(c.start_position);
          vel_q[c.joint_index]  = sext(c.start_velocity);
          phase_q = Q_ONE;
        end
      end
      ACT_TABLE: begin
        wi = (c.joint_index * MAX_SENSORS + c.sensor_index) * MAX_BASIS + c.basis_index;
        if (c.table_select == SEL_WEIGHT && c.joint_index < JOINTS)
          weight_q[wi] = sext(c.table_value);
        else if (c.table_select == SEL_CENTER)
          center_q[c.basis_index] = sext(c.table_value);
        else if (c.table_select == SEL_WIDTH)
          width_q[c.basis_index] = sext(c.table_value);
      end
      default: ;
    endcase
  endtask

  function automatic bit same_result(result_t a, result_t b);
    return a.out_joint == b.out_joint && a.joint_target == b.joint_target &&
           a.joint_rate == b.joint_rate && a.last_joint == b.last_joint;
  endfunction

  initial begin
    errors = 0;
    reset_model();
  end

  assign pending = joint_results.size();

  // watch config writes, command transfers and result strobes
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TIME_SCALE:   tau_r    = cfg_data;
          CFG_OUTER_GAIN:   alpha_r  = cfg_data;
          CFG_POS_RATIO:    beta_r   = cfg_data;
          CFG_STEP_TIME:    dt_r     = cfg_data[24:0];
          CFG_BASIS_COUNT:  basis_r  = cfg_data[3:0];
          CFG_SENSOR_COUNT: sensor_r = cfg_data[1:0];
          default: ;
        endcase
      end
      if (result_valid) begin
        if (joint_results.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer: %p", result);
          errors++;
        end else begin
          want = joint_results.pop_front();
          if (!same_result(want, result)) begin
            if (errors < 10)
              $display("result mismatch: expected joint %0d pos %h vel %h last %b, got joint %0d pos %h vel %h last %b",
                       want.out_joint, want.joint_target, want.joint_rate, want.last_joint,
                       result.out_joint, result.joint_target, result.joint_rate,
                       result.last_joint);
            errors++;
          end
        end
      end
      if (start && !busy) apply_cmd(cmd);
    end
  end

endmodule

// ===== tb/tb_joint_dmp_step.sv =====
// testbench top for joint_dmp_step: drives commands and config, gives the verdict
// depends on jds_pkg, joint_dmp_step and dmp_tick_checker
`timescale 1ns / 1ps

module tb_joint_dmp_step;
  import jds_pkg::*;

  localparam int          STALL_LIMIT = 40000;
  localparam logic [2:0]  CFG_SPARE   = 3'd7;
  localparam logic [1:0]  ACT_NOP     = 2'd3;
  localparam logic [1:0]  SEL_NONE    = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  cmd_t        cmd;
  logic        busy;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  result_t     result;
  logic        result_valid;
  int          pending, errors, quiet_cycles;
  bit          allow_gaps;

  always #1 clk = ~clk;

  joint_dmp_step dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result(result), .result_valid(result_valid)
  );

  dmp_tick_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result(result), .result_valid(result_valid),
    .pending(pending), .errors(errors)
  );

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_write) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one command transfer, with an optional idle burst afterwards
  task automatic send(cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic cmd_t noise_cmd();
    logic [127:0] raw;
    cmd_t c;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    return c;
  endfunction

  function automatic cmd_t tick_cmd();
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_TICK;
    return c;
  endfunction

  function automatic cmd_t start_cmd(logic [2:0] j, logic [31:0] p, logic [31:0] v);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_START;
    c.joint_index = j;
    c.start_position = p;
    c.start_velocity = v;
    return c;
  endfunction

  function automatic cmd_t table_cmd(logic [1:0] sel, logic [2:0] j, logic s,
                                     logic [2:0] b, logic [31:0] v);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_TABLE;
    c.table_select = sel;
    c.joint_index = j;
    c.sensor_index = s;
    c.basis_index = b;
    c.table_value = v;
    return c;
  endfunction

  // moderate values most of the time, any 32-bit word now and then
  function automatic logic [31:0] joint_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
  endfunction

  function automatic logic [31:0] table_word(logic [1:0] sel);
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (sel)
      SEL_WEIGHT: return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
      SEL_CENTER: return 32'($urandom_range(0, 32'h0100_0000));
      default:    return 32'($urandom_range(0, 32'h4000_0000));
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    int pick;
    logic [1:0] sel;
    cmd_t c;
    pick = $urandom_range(0, 99);
    sel = 2'($urandom_range(0, 2));
    if (pick < 40) c = tick_cmd();
    else if (pick < 60)
      c = start_cmd(3'($urandom_range(0, JOINTS - 1)), joint_value(), joint_value());
    else if (pick < 94)
      c = table_cmd(sel, 3'($urandom_range(0, JOINTS - 1)), 1'($urandom),
                    3'($urandom), table_word(sel));
    else begin
      // ignored commands: spare action, joint out of range, spare select
      c = noise_cmd();
      case ($urandom_range(0, 2))
        0: c.action = ACT_NOP;
        1: begin c.action = ACT_START; c.joint_index = 3'd7; end
        default: begin c.action = ACT_TABLE; c.table_select = SEL_NONE; end
      endcase
    end
    return c;
  endfunction

  // config writes while idle; each entry is an index and a value
  task automatic write_setting(logic [30:0] ts, logic [30:0] og, logic [30:0] pr,
                               logic [30:0] st, logic [30:0] bc, logic [30:0] sc);
    logic [2:0]  idx[6];
    logic [30:0] val[6];
    idx = '{CFG_TIME_SCALE, CFG_OUTER_GAIN, CFG_POS_RATIO,
            CFG_STEP_TIME, CFG_BASIS_COUNT, CFG_SENSOR_COUNT};
    val = '{ts, og, pr, st, bc, sc};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // drain outstanding results, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    start <= 1'b0;
    cmd <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst <= 1'b1;
    allow_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every table entry so no tick reads an unwritten word
    for (int b = 0; b < MAX_BASIS; b++) begin
      send(table_cmd(SEL_CENTER, 3'd0, 1'b0, 3'(b), table_word(SEL_CENTER)));
      send(table_cmd(SEL_WIDTH, 3'd0, 1'b0, 3'(b), table_word(SEL_WIDTH)));
    end
    for (int j = 0; j < JOINTS; j++)
      for (int s = 0; s < MAX_SENSORS; s++)
        for (int b = 0; b < MAX_BASIS; b++)
          send(table_cmd(SEL_WEIGHT, 3'(j), 1'(s), 3'(b), table_word(SEL_WEIGHT)));

    // directed: reset defaults, extremes, ignored commands
    send(tick_cmd());
    send(start_cmd(3'd0, MAXV, MINV));
    send(start_cmd(3'd6, MINV, MAXV));
    send(tick_cmd());
    send(tick_cmd());
    send(table_cmd(SEL_WEIGHT, 3'd6, 1'b1, 3'd7, MAXV));
    send(table_cmd(SEL_WEIGHT, 3'd0, 1'b0, 3'd0, MINV));
    send(table_cmd(SEL_CENTER, 3'd0, 1'b0, 3'd7, MAXV));
    send(table_cmd(SEL_WIDTH, 3'd0, 1'b0, 3'd7, 32'd0));
    send(table_cmd(SEL_CENTER, 3'd0, 1'b0, 3'd1, MINV));
    send(table_cmd(SEL_WIDTH, 3'd0, 1'b0, 3'd1, MAXV));
    send(tick_cmd());
    send(start_cmd(3'd7, $urandom, $urandom));
    send(table_cmd(SEL_NONE, 3'd2, 1'b1, 3'd3, $urandom));
    send(table_cmd(SEL_WEIGHT, 3'd7, 1'b0, 3'd3, $urandom));
    begin
      cmd_t c;
      c = noise_cmd();
      c.action = ACT_NOP;
      send(c);
    end
    send(start_cmd(3'd3, 32'd0, 32'd0));
    send(tick_cmd());
    wait_idle();

    // random phases under a range of settings, last one without gaps
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_setting(31'd16777216, 31'd419430400, 31'd104857600, 31'd16777,
                         31'd6, 31'd2);
        1: write_setting(31'd1, 31'h7fffffff, 31'h7fffffff, 31'd16777216, 31'd8, 31'd1);
        2: write_setting(31'h7fffffff, 31'd0, 31'd0, 31'd1, 31'd2, 31'd2);
        3: write_setting(31'd33554432, 31'd167772160, 31'd41943040, 31'd167772,
                         31'd0, 31'd0);
        4: write_setting(31'd8388608, 31'd838860800, 31'd209715200, 31'd33554,
                         31'd15, 31'd3);
        default: write_setting(31'($urandom), 31'($urandom), 31'($urandom),
                               31'($urandom_range(1, 16777216)),
                               31'($urandom_range(2, 8)), 31'($urandom_range(1, 2)));
      endcase
      cfg_write <= 1'b1;
      cfg_index <= CFG_SPARE;
      cfg_data  <= 31'($urandom);
      @(posedge clk);
      cfg_write <= 1'b0;
      allow_gaps = (ph < 5);
      for (int n = 0; n < 30; n++) send(random_cmd());
      wait_idle();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
